### sv/http_request_header_parser_core_defines.svh
// ----------------------------------------------------------------------------
// http request header parser assertion macros
// property wrappers used by the parser engine
// ----------------------------------------------------------------------------
`ifndef HTTP_REQUEST_HEADER_PARSER_CORE_DEFINES_SVH
`define HTTP_REQUEST_HEADER_PARSER_CORE_DEFINES_SVH

// same-cycle implication
`define HRHP_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define HRHP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/hrhp_pkg.sv
// ----------------------------------------------------------------------------
// hrhp_pkg
// shared types and constants of the http request header parser
// ----------------------------------------------------------------------------
package hrhp_pkg;

  localparam int LEN_W      = 21;  // field length counter, saturating
  localparam int VER_W      = 8;   // version value, saturating
  localparam int LIMIT_W    = 20;  // length limit registers
  localparam int CMP_W      = (LEN_W > LIMIT_W) ? LEN_W : LIMIT_W;  // length vs limit
  localparam int CFG_IDX_W  = 3;
  localparam int FIFO_DEPTH = 2;   // power of two
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_METHOD_LIMIT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RESOURCE_LIMIT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_QUERY_LIMIT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HNAME_LIMIT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_HVALUE_LIMIT  = 3'd4;

  localparam logic [LIMIT_W-1:0] RST_METHOD_LIMIT   = 20'd1024;
  localparam logic [LIMIT_W-1:0] RST_RESOURCE_LIMIT = 20'd262144;
  localparam logic [LIMIT_W-1:0] RST_QUERY_LIMIT    = 20'd1048575;
  localparam logic [LIMIT_W-1:0] RST_HNAME_LIMIT    = 20'd1024;
  localparam logic [LIMIT_W-1:0] RST_HVALUE_LIMIT   = 20'd1048575;

  // field kinds
  localparam logic [2:0] FK_NONE   = 3'd0;
  localparam logic [2:0] FK_METHOD = 3'd1;
  localparam logic [2:0] FK_URI    = 3'd2;
  localparam logic [2:0] FK_QUERY  = 3'd3;
  localparam logic [2:0] FK_HNAME  = 3'd4;
  localparam logic [2:0] FK_HVALUE = 3'd5;

  // field end events
  localparam logic [2:0] EK_NONE     = 3'd0;
  localparam logic [2:0] EK_METHOD   = 3'd1;
  localparam logic [2:0] EK_RESOURCE = 3'd2;
  localparam logic [2:0] EK_QUERY    = 3'd3;
  localparam logic [2:0] EK_HEADER   = 3'd4;

  // status
  localparam logic [1:0] ST_BUSY  = 2'd0;
  localparam logic [1:0] ST_DONE  = 2'd1;
  localparam logic [1:0] ST_ERROR = 2'd2;

  // characters
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_QMARK = 8'h3F;
  localparam logic [7:0] CH_H     = 8'h48;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_DEL   = 8'h7F;

  typedef struct packed {
    logic tok;
    logic ctl;
    logic dig;
    logic sp;
    logic tab;
    logic cr;
    logic lf;
    logic colon;
    logic qmark;
    logic dot;
    logic slash;
    logic h;
    logic t;
    logic p;
  } char_class_t;

  typedef struct packed {
    logic [7:0]  data;
    char_class_t cls;
  } fifo_entry_t;

  typedef struct packed {
    logic [LIMIT_W-1:0] method;
    logic [LIMIT_W-1:0] resource;
    logic [LIMIT_W-1:0] query;
    logic [LIMIT_W-1:0] hname;
    logic [LIMIT_W-1:0] hvalue;
  } limits_t;

  // value*10 + digit, saturating at all ones
  function automatic logic [VER_W-1:0] ver_next(input logic [VER_W-1:0] v,
                                                input logic [7:0] c);
    logic [VER_W+3:0] r;
    r = (VER_W+4)'(v) * (VER_W+4)'(10) + (VER_W+4)'(c[3:0]);
    if (r > (VER_W+4)'({VER_W{1'b1}})) begin
      ver_next = {VER_W{1'b1}};
    end else begin
      ver_next = r[VER_W-1:0];
    end
  endfunction

endpackage

### sv/hrhp_classify.sv
// ----------------------------------------------------------------------------
// hrhp_classify
// front end: takes request bytes and tags each with its character classes
// ----------------------------------------------------------------------------
module hrhp_classify (
  input  logic                  data_valid_i,
  input  logic [7:0]            data_byte_i,
  output logic                  data_ready_o,
  output logic                  push_valid_o,
  output hrhp_pkg::fifo_entry_t push_entry_o,
  input  logic                  push_ready_i
);
  import hrhp_pkg::*;

  function automatic logic is_sep(input logic [7:0] c);
    logic r;
    r = 1'b0;
    unique case (c)
      8'h28, 8'h29, 8'h3C, 8'h3E, 8'h40, 8'h2C, 8'h3B, 8'h3A, 8'h5C, 8'h22,
      8'h2F, 8'h5B, 8'h5D, 8'h3F, 8'h3D, 8'h7B, 8'h7D, 8'h20, 8'h09: begin
        r = 1'b1;
      end
      default: begin
        r = 1'b0;
      end
    endcase
    return r;
  endfunction

  logic [7:0]  b;
  char_class_t cls;

  assign b = data_byte_i;

  always_comb begin
    cls.ctl   = (b < 8'd32) || (b == CH_DEL);
    cls.tok   = !b[7] && !cls.ctl && !is_sep(b);
    cls.dig   = (b >= CH_ZERO) && (b <= CH_NINE);
    cls.sp    = (b == CH_SP);
    cls.tab   = (b == CH_TAB);
    cls.cr    = (b == CH_CR);
    cls.lf    = (b == CH_LF);
    cls.colon = (b == CH_COLON);
    cls.qmark = (b == CH_QMARK);
    cls.dot   = (b == CH_DOT);
    cls.slash = (b == CH_SLASH);
    cls.h     = (b == CH_H);
    cls.t     = (b == CH_T);
    cls.p     = (b == CH_P);
  end

  assign push_entry_o.data = b;
  assign push_entry_o.cls  = cls;
  assign push_valid_o      = data_valid_i;
  assign data_ready_o      = push_ready_i;

endmodule

### sv/hrhp_fifo.sv
// ----------------------------------------------------------------------------
// hrhp_fifo
// short word queue between the classifier and the parse engine
// ----------------------------------------------------------------------------
module hrhp_fifo (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_valid_i,
  input  hrhp_pkg::fifo_entry_t push_entry_i,
  output logic                  push_ready_o,
  output logic                  pop_valid_o,
  output hrhp_pkg::fifo_entry_t pop_entry_o,
  input  logic                  pop_ready_i
);
  import hrhp_pkg::*;

  fifo_entry_t        mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_q, wr_ptr_d;
  logic [FIFO_AW-1:0] rd_ptr_q, rd_ptr_d;
  logic [FIFO_AW:0]   cnt_q, cnt_d;
  logic               push, pop;

  assign push_ready_o = (cnt_q != (FIFO_AW+1)'(FIFO_DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_ready_i && pop_valid_o;
  assign pop_entry_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

endmodule

### sv/hrhp_engine.sv
// ----------------------------------------------------------------------------
// hrhp_engine
// back end: request state machine with a registered result stage
// ----------------------------------------------------------------------------
`include "http_request_header_parser_core_defines.svh"

module hrhp_engine (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       entry_valid_i,
  input  hrhp_pkg::fifo_entry_t      entry_i,
  output logic                       entry_ready_o,
  input  hrhp_pkg::limits_t          limits_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [7:0]                 out_byte_o,
  output logic [2:0]                 field_kind_o,
  output logic                       field_clear_o,
  output logic                       append_o,
  output logic [2:0]                 end_kind_o,
  output logic [1:0]                 status_o,
  output logic                       consumed_o,
  output logic [hrhp_pkg::VER_W-1:0] version_major_o,
  output logic [hrhp_pkg::VER_W-1:0] version_minor_o
);
  import hrhp_pkg::*;

  localparam logic [4:0] PH_METHOD_START = 5'd0;
  localparam logic [4:0] PH_METHOD       = 5'd1;
  localparam logic [4:0] PH_URI_STEM     = 5'd2;
  localparam logic [4:0] PH_URI_QUERY    = 5'd3;
  localparam logic [4:0] PH_V_H          = 5'd4;
  localparam logic [4:0] PH_V_T1         = 5'd5;
  localparam logic [4:0] PH_V_T2         = 5'd6;
  localparam logic [4:0] PH_V_P          = 5'd7;
  localparam logic [4:0] PH_V_SLASH      = 5'd8;
  localparam logic [4:0] PH_MAJOR_START  = 5'd9;
  localparam logic [4:0] PH_MAJOR        = 5'd10;
  localparam logic [4:0] PH_MINOR_START  = 5'd11;
  localparam logic [4:0] PH_MINOR        = 5'd12;
  localparam logic [4:0] PH_EXPECT_LF    = 5'd13;
  localparam logic [4:0] PH_EXPECT_CR    = 5'd14;
  localparam logic [4:0] PH_HDR_WS       = 5'd15;
  localparam logic [4:0] PH_HDR_START    = 5'd16;
  localparam logic [4:0] PH_HDR_NAME     = 5'd17;
  localparam logic [4:0] PH_SPACE_VALUE  = 5'd18;
  localparam logic [4:0] PH_HDR_VALUE    = 5'd19;
  localparam logic [4:0] PH_FINAL_LF     = 5'd20;
  localparam logic [4:0] PH_FINAL_CR     = 5'd21;

  logic [4:0]       phase_q, phase_d;
  logic [LEN_W-1:0] len_q, len_d, len_inc;
  logic [VER_W-1:0] maj_q, maj_d, min_q, min_d;
  logic             out_valid_q;
  logic             pop;

  char_class_t cl;
  logic [7:0]  c;
  logic [2:0]  kind, endk;
  logic [1:0]  st;
  logic        clr, app, cons, err, do_name, same, other;

  assign cl  = entry_i.cls;
  assign c   = entry_i.data;
  assign pop = entry_valid_i && (!out_valid_q || out_ready_i);

  assign entry_ready_o = !out_valid_q || out_ready_i;
  assign out_valid_o   = out_valid_q;
  assign len_inc       = (&len_q) ? len_q : len_q + 1'b1;

  always_comb begin
    kind    = FK_NONE;
    clr     = 1'b0;
    app     = 1'b0;
    endk    = EK_NONE;
    st      = ST_BUSY;
    cons    = 1'b1;
    err     = 1'b0;
    do_name = 1'b0;
    same    = 1'b0;
    other   = 1'b0;
    phase_d = phase_q;
    len_d   = len_q;
    maj_d   = maj_q;
    min_d   = min_q;

    unique case (phase_q)
      PH_METHOD: begin
        if (cl.sp) begin
          endk = EK_METHOD; kind = FK_URI; clr = 1'b1;
          len_d = '0; phase_d = PH_URI_STEM;
        end else if (!cl.tok || CMP_W'(len_q) >= CMP_W'(limits_i.method)) begin
          err = 1'b1;
        end else begin
          kind = FK_METHOD; app = 1'b1; len_d = len_inc;
        end
      end
      PH_URI_STEM: begin
        if (cl.sp) begin
          endk = EK_RESOURCE; phase_d = PH_V_H;
        end else if (cl.qmark) begin
          endk = EK_RESOURCE; kind = FK_QUERY; clr = 1'b1;
          len_d = '0; phase_d = PH_URI_QUERY;
        end else if (cl.ctl || CMP_W'(len_q) >= CMP_W'(limits_i.resource)) begin
          err = 1'b1;
        end else begin
          kind = FK_URI; app = 1'b1; len_d = len_inc;
        end
      end
      PH_URI_QUERY: begin
        if (cl.sp) begin
          endk = EK_QUERY; phase_d = PH_V_H;
        end else if (cl.ctl || CMP_W'(len_q) >= CMP_W'(limits_i.query)) begin
          err = 1'b1;
        end else begin
          kind = FK_QUERY; app = 1'b1; len_d = len_inc;
        end
      end
      PH_V_H: begin
        if (!cl.h) err = 1'b1; else phase_d = PH_V_T1;
      end
      PH_V_T1: begin
        if (!cl.t) err = 1'b1; else phase_d = PH_V_T2;
      end
      PH_V_T2: begin
        if (!cl.t) err = 1'b1; else phase_d = PH_V_P;
      end
      PH_V_P: begin
        if (!cl.p) err = 1'b1; else phase_d = PH_V_SLASH;
      end
      PH_V_SLASH: begin
        if (!cl.slash) err = 1'b1; else phase_d = PH_MAJOR_START;
      end
      PH_MAJOR_START: begin
        if (!cl.dig) begin
          err = 1'b1;
        end else begin
          maj_d = ver_next('0, c); phase_d = PH_MAJOR;
        end
      end
      PH_MAJOR: begin
        if (cl.dot) phase_d = PH_MINOR_START;
        else if (cl.dig) maj_d = ver_next(maj_q, c);
        else err = 1'b1;
      end
      PH_MINOR_START: begin
        if (!cl.dig) begin
          err = 1'b1;
        end else begin
          min_d = ver_next('0, c); phase_d = PH_MINOR;
        end
      end
      PH_MINOR: begin
        if (cl.cr) phase_d = PH_EXPECT_LF;
        else if (cl.lf) phase_d = PH_EXPECT_CR;
        else if (cl.dig) min_d = ver_next(min_q, c);
        else err = 1'b1;
      end
      PH_EXPECT_LF, PH_EXPECT_CR: begin
        // line end of the opposite kind completes the pair, a repeat ends headers
        same  = (phase_q == PH_EXPECT_LF) ? cl.cr : cl.lf;
        other = (phase_q == PH_EXPECT_LF) ? cl.lf : cl.cr;
        if (other) begin
          phase_d = PH_HDR_START;
        end else if (same) begin
          st = ST_DONE; phase_d = PH_METHOD_START;
        end else if (cl.tab || cl.sp) begin
          phase_d = PH_HDR_WS;
        end else begin
          do_name = 1'b1;
        end
      end
      PH_HDR_WS: begin
        if (cl.cr) phase_d = PH_EXPECT_LF;
        else if (cl.lf) phase_d = PH_EXPECT_CR;
        else if (!cl.tab && !cl.sp) do_name = 1'b1;
      end
      PH_HDR_START: begin
        if (cl.cr) phase_d = PH_FINAL_LF;
        else if (cl.lf) phase_d = PH_FINAL_CR;
        else if (cl.tab || cl.sp) phase_d = PH_HDR_WS;
        else do_name = 1'b1;
      end
      PH_HDR_NAME: begin
        if (cl.colon) begin
          kind = FK_HVALUE; clr = 1'b1; len_d = '0; phase_d = PH_SPACE_VALUE;
        end else if (!cl.tok || CMP_W'(len_q) >= CMP_W'(limits_i.hname)) begin
          err = 1'b1;
        end else begin
          kind = FK_HNAME; app = 1'b1; len_d = len_inc;
        end
      end
      PH_SPACE_VALUE: begin
        // a value byte that directly follows the colon goes in without a length check
        if (cl.sp) begin
          phase_d = PH_HDR_VALUE;
        end else if (cl.cr) begin
          endk = EK_HEADER; phase_d = PH_EXPECT_LF;
        end else if (cl.lf) begin
          endk = EK_HEADER; phase_d = PH_EXPECT_CR;
        end else if (!cl.tok) begin
          err = 1'b1;
        end else begin
          kind = FK_HVALUE; app = 1'b1; len_d = LEN_W'(1); phase_d = PH_HDR_VALUE;
        end
      end
      PH_HDR_VALUE: begin
        if (cl.cr) begin
          endk = EK_HEADER; phase_d = PH_EXPECT_LF;
        end else if (cl.lf) begin
          endk = EK_HEADER; phase_d = PH_EXPECT_CR;
        end else if (cl.ctl || CMP_W'(len_q) >= CMP_W'(limits_i.hvalue)) begin
          err = 1'b1;
        end else begin
          kind = FK_HVALUE; app = 1'b1; len_d = len_inc;
        end
      end
      PH_FINAL_LF: begin
        cons = cl.lf; st = ST_DONE; phase_d = PH_METHOD_START;
      end
      PH_FINAL_CR: begin
        cons = cl.cr; st = ST_DONE; phase_d = PH_METHOD_START;
      end
      default: begin
        // method start, also taken by unused phase codes
        if (!cl.sp && !cl.cr && !cl.lf) begin
          if (!cl.tok) begin
            err = 1'b1;
          end else begin
            kind = FK_METHOD; clr = 1'b1; app = 1'b1;
            len_d = LEN_W'(1); phase_d = PH_METHOD;
          end
        end
      end
    endcase

    if (do_name) begin
      if (!cl.tok) begin
        err = 1'b1;
      end else begin
        kind = FK_HNAME; clr = 1'b1; app = 1'b1;
        len_d = LEN_W'(1); phase_d = PH_HDR_NAME;
      end
    end

    if (err) begin
      kind = FK_NONE; clr = 1'b0; app = 1'b0; endk = EK_NONE;
      st = ST_ERROR; cons = 1'b1; phase_d = PH_METHOD_START;
    end
    if (err || st == ST_DONE) begin
      len_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_METHOD_START;
      len_q       <= '0;
      maj_q       <= '0;
      min_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop) begin
        phase_q <= phase_d;
        len_q   <= len_d;
        maj_q   <= maj_d;
        min_q   <= min_d;
      end
      if (pop) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      out_byte_o      <= c;
      field_kind_o    <= kind;
      field_clear_o   <= clr;
      append_o        <= app;
      end_kind_o      <= endk;
      status_o        <= st;
      consumed_o      <= cons;
      version_major_o <= maj_d;
      version_minor_o <= min_d;
    end
  end

  `HRHP_ASSERT_IMP(a_error_quiet, clk_i, rst_ni, out_valid_o && status_o == ST_ERROR, field_kind_o == FK_NONE && !append_o && !field_clear_o && end_kind_o == EK_NONE, "error word carries field activity")
  `HRHP_ASSERT_IMP(a_unconsumed_done, clk_i, rst_ni, out_valid_o && !consumed_o, status_o == ST_DONE, "unconsumed byte without completion")
  `HRHP_ASSERT_IMP(a_append_kind, clk_i, rst_ni, out_valid_o && append_o, field_kind_o != FK_NONE, "append with no field")
  `HRHP_ASSERT_NEXT(a_error_restart, clk_i, rst_ni, pop && err, phase_q == PH_METHOD_START && len_q == '0, "no restart after error")

endmodule

### sv/http_request_header_parser_core.sv
// ----------------------------------------------------------------------------
// http_request_header_parser_core: per-byte http request header parser
// path: each accepted byte is queued, then parsed into the registered result stage
// throughput: one byte per cycle while the result output is not held by out_ready_i
// reset: async low, parser at method start, limits at defaults, queue empty
// ----------------------------------------------------------------------------
module http_request_header_parser_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [hrhp_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [hrhp_pkg::LIMIT_W-1:0]   cfg_data_i,
  input  logic                           data_valid_i,
  output logic                           data_ready_o,
  input  logic [7:0]                     data_byte_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [7:0]                     out_byte_o,
  output logic [2:0]                     field_kind_o,
  output logic                           field_clear_o,
  output logic                           append_o,
  output logic [2:0]                     end_kind_o,
  output logic [1:0]                     status_o,
  output logic                           consumed_o,
  output logic [hrhp_pkg::VER_W-1:0]     version_major_o,
  output logic [hrhp_pkg::VER_W-1:0]     version_minor_o
);
  import hrhp_pkg::*;

  limits_t     limits_q;
  logic        push_valid, push_ready, pop_valid, pop_ready;
  fifo_entry_t push_entry, pop_entry;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limits_q.method   <= RST_METHOD_LIMIT;
      limits_q.resource <= RST_RESOURCE_LIMIT;
      limits_q.query    <= RST_QUERY_LIMIT;
      limits_q.hname    <= RST_HNAME_LIMIT;
      limits_q.hvalue   <= RST_HVALUE_LIMIT;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_METHOD_LIMIT:   limits_q.method   <= cfg_data_i;
        CFG_RESOURCE_LIMIT: limits_q.resource <= cfg_data_i;
        CFG_QUERY_LIMIT:    limits_q.query    <= cfg_data_i;
        CFG_HNAME_LIMIT:    limits_q.hname    <= cfg_data_i;
        CFG_HVALUE_LIMIT:   limits_q.hvalue   <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  hrhp_classify u_classify (
    .data_valid_i (data_valid_i),
    .data_byte_i  (data_byte_i),
    .data_ready_o (data_ready_o),
    .push_valid_o (push_valid),
    .push_entry_o (push_entry),
    .push_ready_i (push_ready)
  );

  hrhp_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_entry_i (push_entry),
    .push_ready_o (push_ready),
    .pop_valid_o  (pop_valid),
    .pop_entry_o  (pop_entry),
    .pop_ready_i  (pop_ready)
  );

  hrhp_engine u_engine (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .entry_valid_i   (pop_valid),
    .entry_i         (pop_entry),
    .entry_ready_o   (pop_ready),
    .limits_i        (limits_q),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .out_byte_o      (out_byte_o),
    .field_kind_o    (field_kind_o),
    .field_clear_o   (field_clear_o),
    .append_o        (append_o),
    .end_kind_o      (end_kind_o),
    .status_o        (status_o),
    .consumed_o      (consumed_o),
    .version_major_o (version_major_o),
    .version_minor_o (version_minor_o)
  );

endmodule
